// ===== hw/rtl/magnetization_damping_torque_unit_assert.svh =====
// assertion helpers for the damping torque unit
`ifndef MAGNETIZATION_DAMPING_TORQUE_UNIT_ASSERT_SVH
`define MAGNETIZATION_DAMPING_TORQUE_UNIT_ASSERT_SVH

// checked only while out of reset
`define MDT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mdt assertion failed");

// checked on every edge, reset included
`define MDT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mdt reset assertion failed");

`endif

// ===== hw/rtl/mdt_pkg.sv =====
`default_nettype none

package mdt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIMB_W = 32;
  // m.m and m.h, signed
  localparam int unsigned DOT_W  = 66;
  // d components, signed
  localparam int unsigned D_W    = 97;
  // sum of squares of d, unsigned
  localparam int unsigned SQ_W   = 193;
  localparam int unsigned RT_W   = (SQ_W + 1) / 2;
  // 6 |d|, signed
  localparam int unsigned C_W    = RT_W + 4;
  localparam int unsigned OMM_W  = DOT_W;
  localparam int unsigned K_W    = C_W + OMM_W;
  localparam int unsigned KM_W   = K_W + DATA_W;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              last;
  } res_t;

  // latency of mdt_mul: magnitude, limb products, adder tree, sign
  function automatic int unsigned mdt_mul_lat(int unsigned wa, int unsigned wb);
    int unsigned na;
    int unsigned nb;
    na = (wa + LIMB_W - 1) / LIMB_W;
    nb = (wb + LIMB_W - 1) / LIMB_W;
    return $clog2(na * nb) + 3;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mdt_mul.sv =====
`default_nettype none

module mdt_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import mdt_pkg::*;

  localparam int unsigned NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int unsigned NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int unsigned NP = NA * NB;
  localparam int unsigned LV = $clog2(NP);
  localparam int unsigned NL = 1 << LV;
  localparam int unsigned NN = 2 * NL - 1;
  localparam int unsigned PW = LIMB_W * (NA + NB);
  localparam int unsigned PL = 2 * LIMB_W;

  logic [WA-1:0]          a_abs;
  logic [WB-1:0]          b_abs;
  logic [NA*LIMB_W-1:0]   amag_q;
  logic [NB*LIMB_W-1:0]   bmag_q;
  logic                   sgn_q [LV+2];
  // heap ordered adder tree, leaves hold the shifted limb products
  logic [PW-1:0]          tree_q [NN];
  logic [WA+WB-1:0]       root_mag;
  logic signed [WA+WB-1:0] p_q;

  assign a_abs    = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign b_abs    = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
  assign root_mag = tree_q[0][WA+WB-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      amag_q   <= (NA*LIMB_W)'(a_abs);
      bmag_q   <= (NB*LIMB_W)'(b_abs);
      sgn_q[0] <= a_i[WA-1] ^ b_i[WB-1];
      for (int s = 1; s < LV + 2; s++) begin
        sgn_q[s] <= sgn_q[s-1];
      end
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          tree_q[NL-1+i*NB+j] <= PW'(PL'(amag_q[i*LIMB_W +: LIMB_W]) *
                                     PL'(bmag_q[j*LIMB_W +: LIMB_W])) << (LIMB_W * (i + j));
        end
      end
      for (int n = NP; n < NL; n++) begin
        tree_q[NL-1+n] <= '0;
      end
      for (int n = 0; n < NL - 1; n++) begin
        tree_q[n] <= tree_q[2*n+1] + tree_q[2*n+2];
      end
      p_q <= sgn_q[LV+1] ? -signed'(root_mag) : signed'(root_mag);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mdt_sqrt.sv =====
`default_nettype none

module mdt_sqrt #(
  parameter int unsigned WN = 193
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [WN-1:0]            num_i,
  output logic [(WN+1)/2-1:0]      root_o
);

  localparam int unsigned WR = (WN + 1) / 2;
  localparam int unsigned W2 = 2 * WR;

  logic [W2-1:0] rem_q  [WR];
  logic [WR-1:0] root_q [WR];

  // one result bit per stage, msb first
  always_ff @(posedge clk_i) begin
    logic [W2-1:0] rin;
    logic [W2-1:0] trial;
    logic [WR-1:0] oin;
    if (en_i) begin
      for (int s = 0; s < WR; s++) begin
        rin   = (s == 0) ? W2'(num_i) : rem_q[(s == 0) ? 0 : s-1];
        oin   = (s == 0) ? '0 : root_q[(s == 0) ? 0 : s-1];
        trial = (W2'(oin) << (WR - s)) | (W2'(1) << (2 * (WR - 1 - s)));
        if (rin >= trial) begin
          rem_q[s]  <= rin - trial;
          root_q[s] <= oin | (WR'(1) << (WR - 1 - s));
        end else begin
          rem_q[s]  <= rin;
          root_q[s] <= oin;
        end
      end
    end
  end

  assign root_o = root_q[WR-1];

endmodule

`default_nettype wire

// ===== hw/rtl/magnetization_damping_torque_unit.sv =====
// channel  direction  handshake                 payload
// in       to block   in_valid_i / in_stall_o   mag_*_i, field_*_i, last_node_in_i
// out      from block out_valid_o / out_stall_i rate_*_o, last_node_out_o
//
// one node per cycle while in_stall_o is low; the delay from request to result does not depend on FRAC_BITS
// latency is set mostly by the square root pipeline, one root bit per stage
// reset clears all valid bits, the datapath itself is not reset
// an output register with a skid stage behind it holds results while the
// receiver stalls; the pipeline freezes only once the skid stage is full
`default_nettype none

module magnetization_damping_torque_unit #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mdt_pkg::DATA_W-1:0] mag_x_i,
  input  logic signed [mdt_pkg::DATA_W-1:0] mag_y_i,
  input  logic signed [mdt_pkg::DATA_W-1:0] mag_z_i,
  input  logic signed [mdt_pkg::DATA_W-1:0] field_x_i,
  input  logic signed [mdt_pkg::DATA_W-1:0] field_y_i,
  input  logic signed [mdt_pkg::DATA_W-1:0] field_z_i,
  input  logic                              last_node_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mdt_pkg::DATA_W-1:0] rate_x_o,
  output logic signed [mdt_pkg::DATA_W-1:0] rate_y_o,
  output logic signed [mdt_pkg::DATA_W-1:0] rate_z_o,
  output logic                              last_node_out_o
);
  import mdt_pkg::*;

  localparam int unsigned LM1   = mdt_mul_lat(DOT_W, DATA_W);
  localparam int unsigned LM2   = mdt_mul_lat(D_W, D_W);
  localparam int unsigned LM3   = mdt_mul_lat(C_W, OMM_W);
  localparam int unsigned LM4   = mdt_mul_lat(K_W, DATA_W);
  localparam int unsigned T_D   = 2 + LM1 + 1;
  localparam int unsigned T_SQ  = T_D + LM2 + 1;
  localparam int unsigned T_C   = T_SQ + RT_W + 1;
  localparam int unsigned T_K   = T_C + LM3;
  localparam int unsigned T_KM  = T_K + LM4;
  localparam int unsigned T_OUT = T_KM + 3;
  localparam int unsigned LEN_M = T_K - 2;
  localparam int unsigned LEN_O = T_C - 2;
  localparam int unsigned LEN_D = T_KM - T_D;
  localparam int unsigned RSH   = 5 * FRAC_BITS;
  localparam int unsigned TOT_W = (((D_W + 3 * FRAC_BITS) > KM_W) ?
                                   (D_W + 3 * FRAC_BITS) : KM_W) + 1;
  localparam int unsigned HI_W  = TOT_W - RSH - DATA_W + 1;
  localparam logic signed [OMM_W-1:0] ONE      = OMM_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(1) << (RSH - 1);

  logic en;

  logic signed [DATA_W-1:0] mag_in [3];
  logic signed [DATA_W-1:0] fld_in [3];

  logic signed [2*DATA_W-1:0] pmm_q [3];
  logic signed [2*DATA_W-1:0] pmh_q [3];
  logic signed [DATA_W-1:0]   m1_q  [3];
  logic signed [DATA_W-1:0]   h1_q  [3];
  logic signed [DATA_W-1:0]   m2_q  [3];
  logic signed [DATA_W-1:0]   h2_q  [3];
  logic signed [DOT_W-1:0]    mm_d;
  logic signed [DOT_W-1:0]    mh_d;
  logic signed [DOT_W-1:0]    mm_q;
  logic signed [DOT_W-1:0]    mh_q;
  logic signed [OMM_W-1:0]    omm_q;

  logic signed [DOT_W+DATA_W-1:0] p_mmh [3];
  logic signed [DOT_W+DATA_W-1:0] p_mhm [3];
  logic signed [D_W-1:0]          d_q   [3];
  logic signed [2*D_W-1:0]        p_dsq [3];
  logic [SQ_W-1:0]                sq_q;
  logic [RT_W-1:0]                root;
  logic signed [C_W-1:0]          c_q;
  logic signed [K_W-1:0]          k;
  logic signed [KM_W-1:0]         km    [3];
  logic signed [TOT_W-1:0]        tot_q [3];
  logic signed [TOT_W-1:0]        rnd_q [3];
  logic [DATA_W-1:0]              sat_d [3];
  logic [DATA_W-1:0]              res_q [3];

  logic signed [DATA_W-1:0] m_dly_q   [3][LEN_M];
  logic signed [D_W-1:0]    d_dly_q   [3][LEN_D];
  logic signed [OMM_W-1:0]  omm_dly_q [LEN_O];
  logic                     vld_q     [T_OUT];
  logic                     lst_q     [T_OUT];

  res_t fin;
  res_t out_q;
  res_t skid_q;
  logic out_v_q;
  logic out_v_d;
  logic skid_v_q;
  logic skid_v_d;
  logic load_pipe;
  logic load_skid_out;
  logic load_skid;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  assign mag_in[0] = mag_x_i;
  assign mag_in[1] = mag_y_i;
  assign mag_in[2] = mag_z_i;
  assign fld_in[0] = field_x_i;
  assign fld_in[1] = field_y_i;
  assign fld_in[2] = field_z_i;

  // dot products
  assign mm_d = DOT_W'(pmm_q[0]) + DOT_W'(pmm_q[1]) + DOT_W'(pmm_q[2]);
  assign mh_d = DOT_W'(pmh_q[0]) + DOT_W'(pmh_q[1]) + DOT_W'(pmh_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pmm_q[i] <= mag_in[i] * mag_in[i];
        pmh_q[i] <= mag_in[i] * fld_in[i];
        m1_q[i]  <= mag_in[i];
        h1_q[i]  <= fld_in[i];
        m2_q[i]  <= m1_q[i];
        h2_q[i]  <= h1_q[i];
      end
      mm_q  <= mm_d;
      mh_q  <= mh_d;
      omm_q <= ONE - mm_d;
    end
  end

  // d = (m.m) h - (m.h) m and its squares
  for (genvar g = 0; g < 3; g++) begin : gen_d
    mdt_mul #(.WA(DOT_W), .WB(DATA_W)) u_mul_mmh (
      .clk_i, .en_i(en), .a_i(mm_q), .b_i(h2_q[g]), .p_o(p_mmh[g])
    );
    mdt_mul #(.WA(DOT_W), .WB(DATA_W)) u_mul_mhm (
      .clk_i, .en_i(en), .a_i(mh_q), .b_i(m2_q[g]), .p_o(p_mhm[g])
    );
    mdt_mul #(.WA(D_W), .WB(D_W)) u_mul_dsq (
      .clk_i, .en_i(en), .a_i(d_q[g]), .b_i(d_q[g]), .p_o(p_dsq[g])
    );
    mdt_mul #(.WA(K_W), .WB(DATA_W)) u_mul_km (
      .clk_i, .en_i(en), .a_i(k), .b_i(m_dly_q[g][LEN_M-1]), .p_o(km[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= D_W'(p_mmh[i] - p_mhm[i]);
      end
      // exact, the sum stays below 2^193
      sq_q <= SQ_W'(p_dsq[0] + p_dsq[1] + p_dsq[2]);
      c_q  <= (C_W'(root) << 2) + (C_W'(root) << 1);
    end
  end

  mdt_sqrt #(.WN(SQ_W)) u_sqrt (
    .clk_i,
    .en_i   (en),
    .num_i  (sq_q),
    .root_o (root)
  );

  mdt_mul #(.WA(C_W), .WB(OMM_W)) u_mul_k (
    .clk_i, .en_i(en), .a_i(c_q), .b_i(omm_dly_q[LEN_O-1]), .p_o(k)
  );

  // side data that waits for the long path
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_dly_q[i][0] <= m2_q[i];
        for (int n = 1; n < LEN_M; n++) begin
          m_dly_q[i][n] <= m_dly_q[i][n-1];
        end
        d_dly_q[i][0] <= d_q[i];
        for (int n = 1; n < LEN_D; n++) begin
          d_dly_q[i][n] <= d_dly_q[i][n-1];
        end
      end
      omm_dly_q[0] <= omm_q;
      for (int n = 1; n < LEN_O; n++) begin
        omm_dly_q[n] <= omm_dly_q[n-1];
      end
      lst_q[0] <= last_node_in_i;
      for (int n = 1; n < T_OUT; n++) begin
        lst_q[n] <= lst_q[n-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < T_OUT; n++) begin
        vld_q[n] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int n = 1; n < T_OUT; n++) begin
        vld_q[n] <= vld_q[n-1];
      end
    end
  end

  // sum, round half up, saturate
  always_comb begin
    logic [HI_W-1:0] hi;
    for (int i = 0; i < 3; i++) begin
      hi = rnd_q[i][TOT_W-1:RSH+DATA_W-1];
      if ((&hi) || !(|hi)) begin
        sat_d[i] = rnd_q[i][RSH +: DATA_W];
      end else begin
        sat_d[i] = hi[HI_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tot_q[i] <= (TOT_W'(d_dly_q[i][LEN_D-1]) << (3 * FRAC_BITS)) + TOT_W'(km[i]);
        rnd_q[i] <= tot_q[i] + RND_HALF;
        res_q[i] <= sat_d[i];
      end
    end
  end

  // output register and skid stage
  always_comb begin
    fin.x    = res_q[0];
    fin.y    = res_q[1];
    fin.z    = res_q[2];
    fin.last = lst_q[T_OUT-1];
  end

  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    load_pipe     = 1'b0;
    load_skid_out = 1'b0;
    load_skid     = 1'b0;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d       = 1'b1;
        skid_v_d      = 1'b0;
        load_skid_out = 1'b1;
      end else begin
        out_v_d   = vld_q[T_OUT-1];
        load_pipe = vld_q[T_OUT-1];
      end
    end else if (vld_q[T_OUT-1] && en) begin
      skid_v_d  = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_skid_out) begin
      out_q <= skid_q;
    end else if (load_pipe) begin
      out_q <= fin;
    end
    if (load_skid) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o     = out_v_q;
  assign rate_x_o        = out_q.x;
  assign rate_y_o        = out_q.y;
  assign rate_z_o        = out_q.z;
  assign last_node_out_o = out_q.last;

endmodule

`default_nettype wire

// ===== hw/rtl/mdt_checker.sv =====
`default_nettype none

`include "magnetization_damping_torque_unit_assert.svh"

module mdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] rate_x_o,
  input logic [31:0] rate_y_o,
  input logic [31:0] rate_z_o,
  input logic        last_node_out_o
);

  logic [96:0] out_word;

  assign out_word = {rate_x_o, rate_y_o, rate_z_o, last_node_out_o};

  // a stalled result holds
  `MDT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word))

  // the skid stage only fills behind a held result
  `MDT_ASSERT(a_stall_has_out, in_stall_o |-> out_valid_o)
  `MDT_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))

  `MDT_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o)

endmodule

bind magnetization_damping_torque_unit mdt_checker u_mdt_checker (.*);

`default_nettype wire

// ===== tb/sv/torque_checker.sv =====
`default_nettype none

module torque_checker #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] mag_x_i,
  input  logic [31:0] mag_y_i,
  input  logic [31:0] mag_z_i,
  input  logic [31:0] field_x_i,
  input  logic [31:0] field_y_i,
  input  logic [31:0] field_z_i,
  input  logic        last_node_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] rate_x_i,
  input  logic [31:0] rate_y_i,
  input  logic [31:0] rate_z_i,
  input  logic        last_node_out_i,
  output int          fail_count_o,
  output int          pending_o
);
  import mdt_pkg::*;

  typedef logic signed [255:0] wide_t;

  res_t torque_q[$];

  function automatic logic [255:0] floor_sqrt(logic [255:0] num);
    logic [255:0] root;
    logic [255:0] trial;
    root = '0;
    for (int b = 127; b >= 0; b--) begin
      trial = root | (256'd1 << b);
      if (trial * trial <= num) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] round_sat(wide_t total);
    wide_t v;
    v = (total + (wide_t'(1) <<< (5 * FRAC_BITS - 1))) >>> (5 * FRAC_BITS);
    if (v > wide_t'(64'sd2147483647)) return SAT_MAX;
    if (v < wide_t'(-64'sd2147483648)) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic res_t damping_torque(logic [31:0] mx, logic [31:0] my,
                                          logic [31:0] mz, logic [31:0] hx,
                                          logic [31:0] hy, logic [31:0] hz,
                                          logic last);
    wide_t m[3];
    wide_t h[3];
    wide_t d[3];
    wide_t mm;
    wide_t mh;
    wide_t sq;
    wide_t k;
    logic [31:0] r[3];
    res_t res;
    m[0] = $signed(mx); m[1] = $signed(my); m[2] = $signed(mz);
    h[0] = $signed(hx); h[1] = $signed(hy); h[2] = $signed(hz);
    mm = 0;
    mh = 0;
    for (int i = 0; i < 3; i++) begin
      mm = mm + m[i] * m[i];
      mh = mh + m[i] * h[i];
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = mm * h[i] - mh * m[i];
      sq = sq + d[i] * d[i];
    end
    // 6 |d| (1 - m.m)
    k = wide_t'(6) * $signed(floor_sqrt(sq)) * ((wide_t'(1) <<< (2 * FRAC_BITS)) - mm);
    for (int i = 0; i < 3; i++)
      r[i] = round_sat((d[i] <<< (3 * FRAC_BITS)) + k * m[i]);
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    res.last = last;
    return res;
  endfunction

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (torque_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_r = torque_q.pop_front();
          if (rate_x_i !== exp_r.x) begin
            $error("rate_x expected %h actual %h", exp_r.x, rate_x_i);
            fail_count_o = fail_count_o + 1;
          end
          if (rate_y_i !== exp_r.y) begin
            $error("rate_y expected %h actual %h", exp_r.y, rate_y_i);
            fail_count_o = fail_count_o + 1;
          end
          if (rate_z_i !== exp_r.z) begin
            $error("rate_z expected %h actual %h", exp_r.z, rate_z_i);
            fail_count_o = fail_count_o + 1;
          end
          if (last_node_out_i !== exp_r.last) begin
            $error("last_node_out expected %b actual %b", exp_r.last, last_node_out_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        torque_q.push_back(damping_torque(mag_x_i, mag_y_i, mag_z_i, field_x_i,
                                          field_y_i, field_z_i, last_node_in_i));
      pending_o = torque_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  localparam int unsigned FRAC_BITS = 24;
  localparam int NUM_RANDOM = 1700;
  localparam int QUIET_TAIL = 200;
  localparam logic [31:0] ONE = 32'h0100_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] mag_x_i, mag_y_i, mag_z_i;
  logic [31:0] field_x_i, field_y_i, field_z_i;
  logic        last_node_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] rate_x_o, rate_y_o, rate_z_o;
  logic        last_node_out_o;
  int          fail_count;
  int          pending;
  logic        in_taken;
  bit          quiet;

  magnetization_damping_torque_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .mag_x_i, .mag_y_i, .mag_z_i, .field_x_i, .field_y_i, .field_z_i,
    .last_node_in_i, .out_valid_o, .out_stall_i,
    .rate_x_o, .rate_y_o, .rate_z_o, .last_node_out_o
  );

  torque_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .mag_x_i, .mag_y_i, .mag_z_i, .field_x_i, .field_y_i, .field_z_i,
    .last_node_in_i, .out_valid_i(out_valid_o), .out_stall_i,
    .rate_x_i(rate_x_o), .rate_y_i(rate_y_o), .rate_z_i(rate_z_o),
    .last_node_out_i(last_node_out_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    int len;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 12);
        out_stall_i = 1'b1;
        repeat (len) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_node(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                           logic last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mag_x_i = mx; mag_y_i = my; mag_z_i = mz;
    field_x_i = hx; field_y_i = hy; field_z_i = hz;
    last_node_in_i = last;
    do @(negedge clk_i); while (!in_taken);
  endtask

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      5: return ONE;
      6: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin
    logic [31:0] v[6];
    int kind;
    quiet = 1'b0;
    in_valid_i = 1'b0;
    mag_x_i = '0; mag_y_i = '0; mag_z_i = '0;
    field_x_i = '0; field_y_i = '0; field_z_i = '0;
    last_node_in_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners
    send_node(0, 0, 0, 0, 0, 0, 1'b0);
    send_node(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b1);
    send_node(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_node(32'h7fff_ffff, 32'h8000_0000, 32'h0,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_node(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    // unit magnetization: penalty term vanishes
    send_node(ONE, 0, 0, 0, ONE, 0, 1'b0);
    send_node(0, ONE, 0, ONE, ONE, ONE, 1'b1);
    send_node(0, 0, -ONE, 32'h0300_0000, -ONE, 32'h0050_0000, 1'b0);
    // field parallel to m: no torque
    send_node(ONE, 0, 0, 32'h0200_0000, 0, 0, 1'b1);
    // short and long m, penalty sign flips
    send_node(32'h0080_0000, 32'h0040_0000, 0, 0, ONE, 0, 1'b0);
    send_node(32'h0200_0000, 0, 32'h0100_0000, ONE, ONE, 0, 1'b1);
    send_node(32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 1'b0);
    send_node(32'h0000_0100, 32'h0000_0080, 32'h0000_0001,
              32'h0000_0003, 32'hffff_ff00, 32'h0000_0010, 1'b1);
    send_node(32'h1000_0000, 32'hf000_0000, 32'h0800_0000,
              32'h0000_1000, 32'h0000_2000, 32'hffff_f000, 1'b0);
    send_node(32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 1'b1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
        if (kind < 4) v[i] = (i < 3) ? near(32'h0200_0000) : near(32'h0400_0000);
        else if (kind < 6) v[i] = $urandom;
        else if (kind < 8) v[i] = $signed($urandom) >>> $urandom_range(0, 30);
        else v[i] = corner_value();
      end
      // nearly unit m along one axis
      if (kind == 9) begin
        v[0] = ONE + near(32'h0001_0000);
        v[1] = near(32'h0001_0000);
        v[2] = near(32'h0001_0000);
      end
      send_node(v[0], v[1], v[2], v[3], v[4], v[5], 1'($urandom_range(0, 1)));
    end
    in_valid_i = 1'b0;
    quiet = 1'b1;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
